[hdl/fdr_pkg.sv]
// Shared types and constants for the factor dot residual unit.
// Used by the controller, the datapath, the top level and the checker.
// No other dependencies.
package fdr_pkg;

    // Default table sizes.
    localparam int NUM_USERS_DEF   = 1024;
    localparam int NUM_ITEMS_DEF   = 1024;
    localparam int MAX_FACTORS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int REQ_W    = 2;
    localparam int ROW_W    = 10;
    localparam int SLOT_IN_W = 4;
    localparam int FACTOR_W = 16;
    localparam int RATING_W = 32;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 48;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_USER_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ITEM_LOAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTORS_IN_USE = 2'd1;

    // Configuration reset values.
    localparam logic [RATING_W-1:0] OFFSET_RESET  = '0;
    localparam logic [COUNT_W-1:0]  FACTORS_RESET = 5'd16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_user;
        logic write_item;
        logic capture;
        logic issue;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic out_busy;
    } status_t;

endpackage

[hdl/fdr_ctrl.sv]
// Controller state machine for the factor dot residual unit.
// Depends on fdr_pkg for the state, command and status types.
module fdr_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fdr_pkg::REQ_W-1:0]     req_type,
    output logic                          in_ready,
    input  fdr_pkg::status_t              status,
    output fdr_pkg::cmd_t                 cmd
);

    fdr_pkg::state_t state_reg;
    fdr_pkg::state_t state_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdr_pkg::ST_IDLE:
            begin
                if (in_valid && req_type == fdr_pkg::REQ_QUERY)
                begin
                    state_next = fdr_pkg::ST_RUN;
                end
            end
            fdr_pkg::ST_RUN:
            begin
                if (status.issue_done)
                begin
                    state_next = fdr_pkg::ST_DRAIN;
                end
            end
            fdr_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = fdr_pkg::ST_FINISH;
                end
            end
            fdr_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = fdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            fdr_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.write_user = accept && req_type == fdr_pkg::REQ_USER_LOAD;
                cmd.write_item = accept && req_type == fdr_pkg::REQ_ITEM_LOAD;
                cmd.capture    = accept && req_type == fdr_pkg::REQ_QUERY;
            end
            fdr_pkg::ST_RUN:
            begin
                cmd.issue = !status.issue_done;
            end
            fdr_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            fdr_pkg::ST_FINISH:
            begin
                cmd.finish = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/fdr_dpath.sv]
// Datapath for the factor dot residual unit: factor memories, configuration
// registers, multiply and accumulate pipeline and the output register.
// Depends on fdr_pkg for widths, codes and the command and status types.
module fdr_dpath
#(
    parameter int NUM_USERS   = fdr_pkg::NUM_USERS_DEF,
    parameter int NUM_ITEMS   = fdr_pkg::NUM_ITEMS_DEF,
    parameter int MAX_FACTORS = fdr_pkg::MAX_FACTORS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [fdr_pkg::ROW_W-1:0]             user_index,
    input  logic [fdr_pkg::ROW_W-1:0]             item_index,
    input  logic [fdr_pkg::SLOT_IN_W-1:0]         factor_slot,
    input  logic signed [fdr_pkg::FACTOR_W-1:0]   factor_value,
    input  logic signed [fdr_pkg::RATING_W-1:0]   rating_value,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [fdr_pkg::RATING_W-1:0]   residual,
    output logic                                  saturated,
    input  fdr_pkg::cmd_t                         cmd,
    output fdr_pkg::status_t                      status
);

    // Only rows reachable by a 10-bit index and slots reachable by a load
    // are stored; the slot field sits in the low address bits.
    localparam int ROW_LIMIT = 1 << fdr_pkg::ROW_W;
    localparam int SLOT_LIMIT = 1 << fdr_pkg::SLOT_IN_W;
    localparam int USER_ROWS = (NUM_USERS < ROW_LIMIT) ? NUM_USERS : ROW_LIMIT;
    localparam int ITEM_ROWS = (NUM_ITEMS < ROW_LIMIT) ? NUM_ITEMS : ROW_LIMIT;
    localparam int SLOTS     = (MAX_FACTORS < SLOT_LIMIT) ? MAX_FACTORS : SLOT_LIMIT;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UROW_W    = $clog2(USER_ROWS);
    localparam int IROW_W    = $clog2(ITEM_ROWS);
    localparam int UADDR_W   = UROW_W + SLOT_W;
    localparam int IADDR_W   = IROW_W + SLOT_W;
    localparam int UDEPTH    = USER_ROWS << SLOT_W;
    localparam int IDEPTH    = ITEM_ROWS << SLOT_W;
    localparam int SUM_W     = fdr_pkg::ACC_W + 1;
    localparam int DIFF_W    = fdr_pkg::ACC_W + 2;
    localparam int Q16_W     = fdr_pkg::PROD_W - 8;

    // Factor memories.
    logic [fdr_pkg::FACTOR_W-1:0] user_mem [UDEPTH];
    logic [fdr_pkg::FACTOR_W-1:0] item_mem [IDEPTH];

    // Configuration registers.
    logic signed [fdr_pkg::RATING_W-1:0] offset_reg;
    logic [fdr_pkg::COUNT_W-1:0]         fiu_reg;

    // Query context.
    logic [UROW_W-1:0]                   urow_reg;
    logic [IROW_W-1:0]                   irow_reg;
    logic signed [fdr_pkg::RATING_W-1:0] rating_reg;
    logic [fdr_pkg::COUNT_W-1:0]         n_reg;
    logic [fdr_pkg::COUNT_W-1:0]         n_next;
    logic [fdr_pkg::COUNT_W-1:0]         k_reg;

    // Pipeline.
    logic signed [fdr_pkg::FACTOR_W-1:0] ufac_reg;
    logic signed [fdr_pkg::FACTOR_W-1:0] ifac_reg;
    logic                                rd_vld_reg;
    logic signed [fdr_pkg::PROD_W-1:0]   prod_reg;
    logic                                prod_vld_reg;
    logic signed [fdr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [fdr_pkg::ACC_W-1:0]    acc_next;
    logic signed [Q16_W-1:0]             prod_q16;
    logic signed [SUM_W-1:0]             acc_sum;

    // Result.
    logic signed [DIFF_W-1:0]            diff;
    logic signed [fdr_pkg::RATING_W-1:0] res_next;
    logic                                sat_next;
    logic                                out_valid_reg;
    logic signed [fdr_pkg::RATING_W-1:0] residual_reg;
    logic                                sat_reg;

    logic load_in_range_user;
    logic load_in_range_item;
    logic rows_in_range;

    // Range checks for loads and queries.
    assign load_in_range_user = (32'(factor_slot) < 32'(MAX_FACTORS))
                                && (32'(user_index) < 32'(NUM_USERS));
    assign load_in_range_item = (32'(factor_slot) < 32'(MAX_FACTORS))
                                && (32'(item_index) < 32'(NUM_ITEMS));
    assign rows_in_range = (32'(user_index) < 32'(NUM_USERS))
                           && (32'(item_index) < 32'(NUM_ITEMS));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= fdr_pkg::OFFSET_RESET;
            fiu_reg    <= fdr_pkg::FACTORS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fdr_pkg::CFG_GLOBAL_OFFSET:  offset_reg <= cfg_data;
                fdr_pkg::CFG_FACTORS_IN_USE: fiu_reg <= cfg_data[fdr_pkg::COUNT_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Factor count for the query, clamped; zero when a row is out of range.
    always_comb
    begin
        if (!rows_in_range)
        begin
            n_next = '0;
        end
        else if (32'(fiu_reg) > 32'(MAX_FACTORS))
        begin
            n_next = fdr_pkg::COUNT_W'(MAX_FACTORS);
        end
        else
        begin
            n_next = fiu_reg;
        end
    end

    // User memory: load writes and query reads.
    always_ff @(posedge clk)
    begin
        if (cmd.write_user && load_in_range_user)
        begin
            user_mem[{user_index[UROW_W-1:0], factor_slot[SLOT_W-1:0]}] <= factor_value;
        end
        ufac_reg <= user_mem[UADDR_W'({urow_reg, k_reg[SLOT_W-1:0]})];
    end

    // Item memory: load writes and query reads.
    always_ff @(posedge clk)
    begin
        if (cmd.write_item && load_in_range_item)
        begin
            item_mem[{item_index[IROW_W-1:0], factor_slot[SLOT_W-1:0]}] <= factor_value;
        end
        ifac_reg <= item_mem[IADDR_W'({irow_reg, k_reg[SLOT_W-1:0]})];
    end

    // Query context capture and factor counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.capture)
        begin
            k_reg <= '0;
            n_reg <= n_next;
        end
        else if (cmd.issue)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            urow_reg   <= user_index[UROW_W-1:0];
            irow_reg   <= item_index[IROW_W-1:0];
            rating_reg <= rating_value;
        end
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        prod_reg <= fdr_pkg::PROD_W'(ufac_reg) * fdr_pkg::PROD_W'(ifac_reg);
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // Floor to Q.16 and saturating accumulate.
    always_comb
    begin
        prod_q16 = prod_reg[fdr_pkg::PROD_W-1:8];
        acc_sum  = {acc_reg[fdr_pkg::ACC_W-1], acc_reg}
                   + {{(SUM_W - Q16_W){prod_q16[Q16_W-1]}}, prod_q16};
        if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2])
        begin
            acc_next = acc_sum[SUM_W-1] ? {1'b1, {(fdr_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(fdr_pkg::ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_sum[fdr_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Residual and clip to 32 bits.
    always_comb
    begin
        diff = {{(DIFF_W - fdr_pkg::RATING_W){rating_reg[fdr_pkg::RATING_W-1]}}, rating_reg}
               - {{(DIFF_W - fdr_pkg::RATING_W){offset_reg[fdr_pkg::RATING_W-1]}}, offset_reg}
               - {{(DIFF_W - fdr_pkg::ACC_W){acc_reg[fdr_pkg::ACC_W-1]}}, acc_reg};
        if (diff[DIFF_W-1:fdr_pkg::RATING_W-1] == '0
            || diff[DIFF_W-1:fdr_pkg::RATING_W-1] == '1)
        begin
            res_next = diff[fdr_pkg::RATING_W-1:0];
            sat_next = 1'b0;
        end
        else
        begin
            res_next = diff[DIFF_W-1] ? {1'b1, {(fdr_pkg::RATING_W-1){1'b0}}}
                                      : {1'b0, {(fdr_pkg::RATING_W-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            residual_reg <= res_next;
            sat_reg      <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign residual  = residual_reg;
    assign saturated = sat_reg;

    // Status to the controller.
    assign status.issue_done = (k_reg >= n_reg);
    assign status.pipe_busy  = rd_vld_reg || prod_vld_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule

[hdl/factor_dot_residual_unit.sv]
// Top level of the factor dot residual unit: controller plus datapath.
// Depends on fdr_pkg, fdr_ctrl and fdr_dpath.
//
//   Channel | Handshake            | Words carried
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | req_type, user_index, item_index, factor_slot,
//           |                      | factor_value, rating_value
//   out     | out_valid/out_ready  | residual, saturated (one word per query)
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load word writes the factor memory on accept; the input side stays open.
// A query holds the input side closed until its result is registered. For the
// clamped factor count, it makes one memory read per factor on each factor
// memory, then passes a product and an accumulate stage before the result
// is registered.
// After reset the factor memories hold unknown data until loaded; no clear pass.
// A finished result waits in the output register while the next word is taken;
// a stalled output holds back only the end of the following query.
module factor_dot_residual_unit
#(
    parameter int NUM_USERS   = fdr_pkg::NUM_USERS_DEF,
    parameter int NUM_ITEMS   = fdr_pkg::NUM_ITEMS_DEF,
    parameter int MAX_FACTORS = fdr_pkg::MAX_FACTORS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fdr_pkg::REQ_W-1:0]             req_type,
    input  logic [fdr_pkg::ROW_W-1:0]             user_index,
    input  logic [fdr_pkg::ROW_W-1:0]             item_index,
    input  logic [fdr_pkg::SLOT_IN_W-1:0]         factor_slot,
    input  logic signed [fdr_pkg::FACTOR_W-1:0]   factor_value,
    input  logic signed [fdr_pkg::RATING_W-1:0]   rating_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fdr_pkg::RATING_W-1:0]   residual,
    output logic                                  saturated
);

    fdr_pkg::cmd_t    cmd;
    fdr_pkg::status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    fdr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Memories and arithmetic.
    fdr_dpath
    #(
        .NUM_USERS   (NUM_USERS),
        .NUM_ITEMS   (NUM_ITEMS),
        .MAX_FACTORS (MAX_FACTORS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .user_index   (user_index),
        .item_index   (item_index),
        .factor_slot  (factor_slot),
        .factor_value (factor_value),
        .rating_value (rating_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .residual     (residual),
        .saturated    (saturated),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[hdl/fdr_checker.sv]
// Port-level checker for the factor dot residual unit, bound to the top level.
// Depends on fdr_pkg for field widths and request codes.
module fdr_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic [fdr_pkg::REQ_W-1:0]             req_type,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [fdr_pkg::RATING_W-1:0]   residual,
    input logic                                  saturated
);

    // A clipped result sits at one end of the 32-bit range.
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (residual == 32'sh7FFFFFFF || residual == 32'sh80000000))
        else $error("saturated word is not at a range limit");

    // A query keeps the input side closed on the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == fdr_pkg::REQ_QUERY) |=> !in_ready)
        else $error("input taken right after a query");

    // A load word leaves the input side open on the next cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready
         && (req_type == fdr_pkg::REQ_USER_LOAD || req_type == fdr_pkg::REQ_ITEM_LOAD))
        |=> in_ready)
        else $error("input side closed after a load");

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(residual) && $stable(saturated)))
        else $error("output word changed while stalled");

endmodule

bind factor_dot_residual_unit fdr_checker u_fdr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .residual  (residual),
    .saturated (saturated)
);
